// ===== hdl/biph_pkg.sv =====
`default_nettype none

package biph_pkg;

  // Item kinds carried in the mode field.
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Edge interval classes. Every other code is a bad edge.
  localparam logic [1:0] CLS_SHORT = 2'd1;
  localparam logic [1:0] CLS_LONG  = 2'd2;

  // Frame length register: reset value and legal range.
  localparam logic [4:0] FRAME_LEN_RESET = 5'd14;
  localparam logic [4:0] FRAME_LEN_MIN   = 5'd2;
  localparam logic [4:0] FRAME_LEN_MAX   = 5'd16;

  localparam int unsigned WORD_W = 16;

  typedef struct packed {
    logic       mode;
    logic [1:0] pulse_class;
    logic       timeout;
  } in_t;

  typedef struct packed {
    logic              frame_valid;
    logic [WORD_W-1:0] frame_word;
    logic              frame_done;
    logic              overflow;
    logic [3:0]        queued_frames;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/biphase_ir_frame_receiver.sv =====
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_ready_o      | in_data_i  (biph_pkg::in_t)
// out     | output    | out_valid_o / out_ready_i    | out_data_o (biph_pkg::out_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o    | cfg_data_i (frame length, 5 bits)
//
// One item per cycle is sustained while the output is not stalled; a result passes
// through the memory read stage, which holds the synchronous read of the frame
// memory, and then the output register. Reset clears the decoder, the queue
// pointers and the fill count; the frame memory is not cleared, since only written
// entries are ever popped. A stalled output holds its result while one more item
// can still enter the memory read stage; after that the input stalls too.

`default_nettype none

module biphase_ir_frame_receiver #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire biph_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output biph_pkg::out_t       out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [4:0]            cfg_data_i
);
  import biph_pkg::*;

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_MID1   = 3'd1;
  localparam logic [2:0] PH_START1 = 3'd2;
  localparam logic [2:0] PH_MID0   = 3'd3;
  localparam logic [2:0] PH_START0 = 3'd4;

  // The bit count stops at its top value, which no legal frame length reaches,
  // so a frame that outgrew a shortened length never completes.
  localparam logic [4:0] CNT_TOP = 5'd31;

  // Configuration
  logic [4:0] frame_len_q;
  logic [4:0] frame_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FRAME_LEN_RESET;
    end else if (cfg_valid_i) begin
      frame_len_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (frame_len_q < FRAME_LEN_MIN) begin
      frame_len = FRAME_LEN_MIN;
    end else if (frame_len_q > FRAME_LEN_MAX) begin
      frame_len = FRAME_LEN_MAX;
    end else begin
      frame_len = frame_len_q;
    end
  end

  // Pipeline control
  logic in_acc;
  logic s1_valid_q;
  logic s1_move;

  assign s1_move    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decoder and queue control state
  logic [2:0]        phase_q, phase_d;
  logic [WORD_W-1:0] shift_q, shift_d;
  logic [4:0]        count_q, count_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0]  fill_q, fill_d;

  logic [2:0]        ph;
  logic [4:0]        cnt;
  logic [WORD_W-1:0] wrd;
  logic              is_read;
  logic              pop;
  logic              push;
  logic              ovf;
  logic              q_full;
  logic [FillW+3:0]  fill_ext;
  out_t              res;

  assign is_read = (in_data_i.mode == MODE_READ);
  assign q_full  = (fill_q == FillW'(QUEUE_DEPTH));

  always_comb begin
    ph      = phase_q;
    cnt     = count_q;
    wrd     = shift_q;
    pop     = 1'b0;
    push    = 1'b0;
    ovf     = 1'b0;
    phase_d = phase_q;
    count_d = count_q;
    shift_d = shift_q;

    if (is_read) begin
      pop = (fill_q != '0);
    end else begin
      if (in_data_i.timeout) begin
        ph  = PH_START;
        cnt = 5'd0;
      end
      case (ph)
        PH_MID1: begin
          if (in_data_i.pulse_class == CLS_SHORT) begin
            ph = PH_START1;
          end else if (in_data_i.pulse_class == CLS_LONG) begin
            wrd = {wrd[WORD_W-2:0], 1'b0};
            cnt = (cnt == CNT_TOP) ? cnt : cnt + 5'd1;
            ph  = PH_MID0;
          end else begin
            ph  = PH_START;
            cnt = 5'd0;
          end
        end
        PH_START1: begin
          if (in_data_i.pulse_class == CLS_SHORT) begin
            wrd = {wrd[WORD_W-2:0], 1'b1};
            cnt = (cnt == CNT_TOP) ? cnt : cnt + 5'd1;
            ph  = PH_MID1;
          end else begin
            ph  = PH_START;
            cnt = 5'd0;
          end
        end
        PH_MID0: begin
          if (in_data_i.pulse_class == CLS_SHORT) begin
            ph = PH_START0;
          end else if (in_data_i.pulse_class == CLS_LONG) begin
            wrd = {wrd[WORD_W-2:0], 1'b1};
            cnt = (cnt == CNT_TOP) ? cnt : cnt + 5'd1;
            ph  = PH_MID1;
          end else begin
            ph  = PH_START;
            cnt = 5'd0;
          end
        end
        PH_START0: begin
          if (in_data_i.pulse_class == CLS_SHORT) begin
            wrd = {wrd[WORD_W-2:0], 1'b0};
            cnt = (cnt == CNT_TOP) ? cnt : cnt + 5'd1;
            ph  = PH_MID0;
          end else begin
            ph  = PH_START;
            cnt = 5'd0;
          end
        end
        default: begin
          // The first edge of a frame supplies the leading one, whatever its class.
          wrd = WORD_W'(1);
          cnt = 5'd1;
          ph  = PH_MID1;
        end
      endcase
      if (cnt == frame_len) begin
        push = !q_full;
        ovf  = q_full;
        ph   = PH_START;
        cnt  = 5'd0;
      end
      phase_d = ph;
      count_d = cnt;
      shift_d = wrd;
    end

    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      fill_d   = fill_q - FillW'(1);
    end
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      fill_d   = fill_q + FillW'(1);
    end

    fill_ext          = {4'd0, fill_d};
    res.frame_valid   = pop;
    res.frame_word    = '0;
    res.frame_done    = push;
    res.overflow      = ovf;
    res.queued_frames = fill_ext[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      shift_q  <= '0;
      count_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Frame memory. A pop only reads an entry written by an earlier transaction,
  // which the write port has already committed, so no forwarding is needed.
  logic [WORD_W-1:0] store_q [QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && push) begin
      store_q[wr_ptr_q] <= wrd;
    end
    if (in_acc && pop) begin
      rd_data_q <= store_q[rd_ptr_q];
    end
  end

  // Memory read stage
  out_t s1_res_q;
  out_t s1_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q <= res;
    end
  end

  always_comb begin
    s1_out            = s1_res_q;
    s1_out.frame_word = s1_res_q.frame_valid ? rd_data_q : '0;
  end

  // Output register
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= s1_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read && fill_q != '0) |=> (fill_q == $past(fill_q) - FillW'(1)))
    else $error("pop did not lower fill count");

  a_done_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.frame_done && out_data_o.overflow) &&
                    !(out_data_o.frame_valid && out_data_o.frame_done))
    else $error("conflicting result flags");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_START0)
    else $error("decoder phase holds an unused code");

endmodule

`default_nettype wire
